// ----- src/drwr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package drwr_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CFG_WIDTH      = 13;
   localparam int ROW_WIDTH      = 16;
   localparam int LINE_WIDTH     = CFG_WIDTH + 1;
   localparam int BYTE_IDX_WIDTH = 4;

   localparam logic [CFG_WIDTH-1:0] PANEL_COLUMNS_RESET = 13'd480;
   localparam logic [CFG_WIDTH-1:0] PANEL_ROWS_RESET    = 13'd320;

   localparam logic REG_PANEL_COLUMNS = 1'b0;
   localparam logic REG_PANEL_ROWS    = 1'b1;

   localparam logic [1:0] ACT_ROW_MARK  = 2'd0;
   localparam logic [1:0] ACT_PAGE_MARK = 2'd1;
   localparam logic [1:0] ACT_FLUSH     = 2'd2;

   localparam logic [7:0] CMD_COLUMNS = 8'h2A;
   localparam logic [7:0] CMD_PAGES   = 8'h2B;
   localparam logic [7:0] CMD_WRITE   = 8'h2C;

   localparam logic [BYTE_IDX_WIDTH-1:0] LAST_BYTE_IDX = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_EMIT
   } drwr_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } drwr_div_status_type;

endpackage

`default_nettype wire

// ----- src/drwr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module drwr_div
   import drwr_pkg::*;
#(
   parameter int DW = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DW-1:0]              dividend,
   input  logic [LINE_WIDTH-1:0]      divisor,
   output logic [DW-1:0]              quotient,
   output drwr_div_status_type        status
);

   localparam int CW = $clog2(DW);

   logic [LINE_WIDTH-1:0] rem_ff, rem_in;
   logic [DW-1:0]         quo_ff, quo_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  active_ff, active_in;
   logic                  done_ff, done_in;

   logic [LINE_WIDTH:0]   trial;
   logic [LINE_WIDTH:0]   diff;
   logic                  fits;

   // One restoring step per cycle; dividend bits shift out as quotient bits shift in.
   always_comb begin
      trial     = {rem_ff, quo_ff[DW-1]};
      diff      = trial - {1'b0, divisor};
      fits      = (trial >= {1'b0, divisor});
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = '0;
         quo_in    = dividend;
         count_in  = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in   = fits ? diff[LINE_WIDTH-1:0] : trial[LINE_WIDTH-1:0];
         quo_in   = {quo_ff[DW-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(DW - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = active_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ----- src/dirty_row_window_refresh.sv -----
// Row mark: accepted without leaving idle, so ready stays high.
// Page mark: two divisions in turn, ST_DIV_LO then ST_DIV_HI, through one
//   shared divider that resolves one quotient bit per cycle.
// Flush: first byte in the cycle after accept, then one byte per cycle while
//   rsp_ready holds; eleven bytes. No new transaction until the last is taken.
// Reset: synchronous; columns 480, rows 320, dirty range cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module dirty_row_window_refresh
   import drwr_pkg::*;
#(
   parameter int PAGE_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic                      req_whole_frame,
   input  logic [11:0]               req_row_start,
   input  logic [12:0]               req_row_count,
   input  logic [11:0]               req_page_index,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_is_parameter,
   output logic [7:0]                rsp_link_byte,
   output logic [11:0]               rsp_window_first_row,
   output logic [11:0]               rsp_window_last_row,
   output logic                      rsp_last,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int DW = 12 + PAGE_BITS;

   drwr_state_type state_ff, state_in;

   logic [CFG_WIDTH-1:0]      panel_columns_ff, panel_columns_in;
   logic [CFG_WIDTH-1:0]      panel_rows_ff, panel_rows_in;
   logic [ROW_WIDTH-1:0]      dirty_first_ff, dirty_first_in;
   logic [ROW_WIDTH-1:0]      dirty_last_ff, dirty_last_in;
   logic [ROW_WIDTH-1:0]      win_first_ff, win_first_in;
   logic [ROW_WIDTH-1:0]      win_last_ff, win_last_in;
   logic [BYTE_IDX_WIDTH-1:0] byte_idx_ff, byte_idx_in;
   logic [11:0]               page_ff, page_in;
   logic [DW-1:0]             lo_ff, lo_in;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      csr_write;
   logic [ROW_WIDTH-1:0]      lastrow;
   logic [ROW_WIDTH-1:0]      col_end;
   logic [11:0]               mark_y;
   logic [12:0]               mark_n;
   logic [13:0]               mark_sum;
   logic [ROW_WIDTH-1:0]      mark_hi;
   logic [ROW_WIDTH-1:0]      page_hi;
   logic                      bad_range;

   logic                      div_start;
   logic [DW-1:0]             div_dividend;
   logic [DW-1:0]             div_quotient;
   drwr_div_status_type       div_status;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign lastrow   = {3'b000, panel_rows_ff} - 16'd1;
   assign col_end   = {3'b000, panel_columns_ff} - 16'd1;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_PANEL_ROWS)
                     ? {{(CSR_DATA_WIDTH-CFG_WIDTH){1'b0}}, panel_rows_ff}
                     : {{(CSR_DATA_WIDTH-CFG_WIDTH){1'b0}}, panel_columns_ff};

   drwr_div #(
      .DW(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ({panel_columns_ff, 1'b0}),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_PAGE_MARK: state_in = ST_DIV_LO;
                  ACT_FLUSH:     state_in = ST_EMIT;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV_LO: if (div_status.done) state_in = ST_DIV_HI;
         ST_DIV_HI: if (div_status.done) state_in = ST_IDLE;
         ST_EMIT: begin
            if (rsp_fire && byte_idx_ff == LAST_BYTE_IDX) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      rsp_valid    = (state_ff == ST_EMIT);
      div_start    = 1'b0;
      div_dividend = {page_ff, {PAGE_BITS{1'b1}}};
      case (state_ff)
         ST_IDLE: begin
            div_start    = req_fire && (req_action == ACT_PAGE_MARK);
            div_dividend = {req_page_index, {PAGE_BITS{1'b0}}};
         end
         ST_DIV_LO: div_start = div_status.done;
         default:   div_start = 1'b0;
      endcase
   end

   // Row mark end, saturating; page mark end clamped to the last row; window range check
   always_comb begin
      mark_y   = req_whole_frame ? 12'd0 : req_row_start;
      mark_n   = req_whole_frame ? panel_rows_ff : req_row_count;
      mark_sum = {2'b00, mark_y} + {1'b0, mark_n};
      mark_hi  = (mark_sum == 14'd0) ? {ROW_WIDTH{1'b1}}
                                     : {2'b00, mark_sum - 14'd1};
      page_hi  = (div_quotient > {{(DW-ROW_WIDTH){1'b0}}, lastrow})
               ? lastrow : div_quotient[ROW_WIDTH-1:0];
      bad_range = (dirty_first_ff > dirty_last_ff) || (dirty_first_ff > lastrow)
               || (dirty_last_ff > lastrow);
   end

   // Datapath next values
   always_comb begin
      panel_columns_in = panel_columns_ff;
      panel_rows_in    = panel_rows_ff;
      dirty_first_in   = dirty_first_ff;
      dirty_last_in    = dirty_last_ff;
      win_first_in     = win_first_ff;
      win_last_in      = win_last_ff;
      byte_idx_in      = byte_idx_ff;
      page_in          = page_ff;
      lo_in            = lo_ff;

      if (csr_write) begin
         if (csr_paddr[2] == REG_PANEL_ROWS) panel_rows_in = csr_pwdata[CFG_WIDTH-1:0];
         else                                panel_columns_in = csr_pwdata[CFG_WIDTH-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            page_in     = req_page_index;
            byte_idx_in = '0;
            if (req_fire && req_action == ACT_ROW_MARK) begin
               if ({4'b0000, mark_y} < dirty_first_ff) dirty_first_in = {4'b0000, mark_y};
               if (mark_hi > dirty_last_ff)            dirty_last_in  = mark_hi;
            end
            if (req_fire && req_action == ACT_FLUSH) begin
               // Fall back to the whole frame on an inverted or out-of-range window
               win_first_in   = bad_range ? '0 : dirty_first_ff;
               win_last_in    = bad_range ? lastrow : dirty_last_ff;
               dirty_first_in = lastrow;
               dirty_last_in  = '0;
            end
         end
         ST_DIV_LO: if (div_status.done) lo_in = div_quotient;
         ST_DIV_HI: begin
            if (div_status.done) begin
               if (lo_ff < {{(DW-ROW_WIDTH){1'b0}}, dirty_first_ff})
                  dirty_first_in = lo_ff[ROW_WIDTH-1:0];
               if (page_hi > dirty_last_ff) dirty_last_in = page_hi;
            end
         end
         ST_EMIT: if (rsp_fire) byte_idx_in = byte_idx_ff + 1'b1;
         default: byte_idx_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      win_first_ff <= win_first_in;
      win_last_ff  <= win_last_in;
      page_ff      <= page_in;
      lo_ff        <= lo_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         panel_columns_ff <= PANEL_COLUMNS_RESET;
         panel_rows_ff    <= PANEL_ROWS_RESET;
         dirty_first_ff   <= '0;
         dirty_last_ff    <= '0;
         byte_idx_ff      <= '0;
      end else begin
         state_ff         <= state_in;
         panel_columns_ff <= panel_columns_in;
         panel_rows_ff    <= panel_rows_in;
         dirty_first_ff   <= dirty_first_in;
         dirty_last_ff    <= dirty_last_in;
         byte_idx_ff      <= byte_idx_in;
      end
   end

   // Command and parameter byte for the current position
   always_comb begin
      rsp_is_parameter = 1'b1;
      rsp_link_byte    = 8'h00;
      rsp_last         = 1'b0;
      case (byte_idx_ff)
         4'd0: begin
            rsp_is_parameter = 1'b0;
            rsp_link_byte    = CMD_COLUMNS;
         end
         4'd1:  rsp_link_byte = 8'h00;
         4'd2:  rsp_link_byte = 8'h00;
         4'd3:  rsp_link_byte = col_end[15:8];
         4'd4:  rsp_link_byte = col_end[7:0];
         4'd5: begin
            rsp_is_parameter = 1'b0;
            rsp_link_byte    = CMD_PAGES;
         end
         4'd6:  rsp_link_byte = win_first_ff[15:8];
         4'd7:  rsp_link_byte = win_first_ff[7:0];
         4'd8:  rsp_link_byte = win_last_ff[15:8];
         4'd9:  rsp_link_byte = win_last_ff[7:0];
         4'd10: begin
            rsp_is_parameter = 1'b0;
            rsp_link_byte    = CMD_WRITE;
            rsp_last         = 1'b1;
         end
         default: rsp_link_byte = 8'h00;
      endcase
   end

   assign rsp_window_first_row = win_first_ff[11:0];
   assign rsp_window_last_row  = win_last_ff[11:0];

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while flush bytes pending");

   a_window_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (win_first_ff <= win_last_ff))
      else $error("refresh window inverted");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last) |=> req_ready)
      else $error("sequencer did not return to idle after last byte");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV_LO || state_ff == ST_DIV_HI))
      else $error("divider finished outside a page mark");

   a_div_busy_page: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_ready)
      else $error("ready while divider busy");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import drwr_pkg::*;

   localparam int PAGE_SIZE_LOG2 = 12;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // bit k set: byte k of a flush is a parameter byte
   localparam logic [10:0] PARAM_SLOTS = 11'b01111011110;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 44;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic        is_parameter;
      logic [7:0]  link_byte;
      logic [11:0] first_row;
      logic [11:0] last_row;
      logic        last;
   } link_beat_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        whole_frame;
      logic [11:0] row_start;
      logic [12:0] row_count;
      logic [11:0] page_index;
      logic        typed;
      logic [15:0] want_first;
      logic [15:0] want_last;
   } panel_event_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_action = ACT_ROW_MARK;
   logic                      req_whole_frame = 1'b0;
   logic [11:0]               req_row_start = '0;
   logic [12:0]               req_row_count = '0;
   logic [11:0]               req_page_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_is_parameter;
   logic [7:0]                rsp_link_byte;
   logic [11:0]               rsp_window_first_row;
   logic [11:0]               rsp_window_last_row;
   logic                      rsp_last;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // predictor copy of the block's registers and dirty range
   logic [12:0] cfg_columns = PANEL_COLUMNS_RESET;
   logic [12:0] cfg_rows = PANEL_ROWS_RESET;
   logic [15:0] track_first = '0;
   logic [15:0] track_last = '0;

   link_beat_type   pending_bytes[$];
   panel_event_type script[$];
   int unsigned     fault_count = 0;
   int unsigned     beat_count = 0;
   int unsigned     hold_left = 0;
   bit              send_calm = 1'b0;
   bit              recv_calm = 1'b0;

   dirty_row_window_refresh #(
      .PAGE_BITS(PAGE_SIZE_LOG2)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_whole_frame     (req_whole_frame),
      .req_row_start       (req_row_start),
      .req_row_count       (req_row_count),
      .req_page_index      (req_page_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_is_parameter    (rsp_is_parameter),
      .rsp_link_byte       (rsp_link_byte),
      .rsp_window_first_row(rsp_window_first_row),
      .rsp_window_last_row (rsp_window_last_row),
      .rsp_last            (rsp_last),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(10, 25);
   endfunction

   function automatic panel_event_type make_event(input logic [1:0] action, input logic whole,
                                                  input int unsigned start,
                                                  input int unsigned count,
                                                  input int unsigned page, input logic typed,
                                                  input int unsigned want_s,
                                                  input int unsigned want_e);
      panel_event_type ev;
      ev.action = action;
      ev.whole_frame = whole;
      ev.row_start = 12'(start);
      ev.row_count = 13'(count);
      ev.page_index = 12'(page);
      ev.typed = typed;
      ev.want_first = 16'(want_s);
      ev.want_last = 16'(want_e);
      return ev;
   endfunction

   function automatic panel_event_type random_event();
      panel_event_type ev;
      int unsigned r;
      int unsigned row_span;
      row_span = (cfg_rows > 13'd4095) ? 4095 : {19'd0, cfg_rows};
      r = $urandom_range(0, 99);
      if (r < 40) ev.action = ACT_ROW_MARK;
      else if (r < 70) ev.action = ACT_PAGE_MARK;
      else if (r < 95) ev.action = ACT_FLUSH;
      else ev.action = ACT_UNUSED;
      ev.whole_frame = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 6) ev.row_start = 12'($urandom_range(0, row_span));
      else ev.row_start = 12'($urandom);
      r = $urandom_range(0, 9);
      if (r < 7) ev.row_count = 13'($urandom_range(0, 16));
      else if (r < 9) ev.row_count = 13'($urandom_range(0, 4096));
      else ev.row_count = 13'($urandom);
      if ($urandom_range(0, 9) < 7) ev.page_index = 12'($urandom_range(0, 80));
      else ev.page_index = 12'($urandom);
      ev.typed = 1'b0;
      ev.want_first = '0;
      ev.want_last = '0;
      return ev;
   endfunction

   task automatic widen_range(input logic [31:0] lo, input logic [31:0] hi);
      if (lo < {16'd0, track_first}) track_first = lo[15:0];
      if (hi > {16'd0, track_last}) track_last = hi[15:0];
   endtask

   task automatic track_event(input panel_event_type ev, output bit flushed,
                              output logic [15:0] s, output logic [15:0] e,
                              output logic [15:0] xe);
      logic [15:0] final_row;
      logic [31:0] y, n, span, lo, hi, base, top;
      logic [13:0] line;
      final_row = {3'b0, cfg_rows} - 16'd1;
      xe = {3'b0, cfg_columns} - 16'd1;
      flushed = 1'b0;
      s = '0;
      e = '0;
      case (ev.action)
         ACT_ROW_MARK: begin
            y = ev.whole_frame ? 32'd0 : {20'd0, ev.row_start};
            n = ev.whole_frame ? {19'd0, cfg_rows} : {19'd0, ev.row_count};
            span = y + n;
            // a count of zero at row zero wraps below zero: saturate
            if (span == 0 || span - 1 > 32'hFFFF) hi = 32'hFFFF;
            else hi = span - 1;
            widen_range(y, hi);
         end
         ACT_PAGE_MARK: begin
            line = {cfg_columns, 1'b0};
            base = {20'd0, ev.page_index} << PAGE_SIZE_LOG2;
            top = base + (32'd1 << PAGE_SIZE_LOG2) - 1;
            // zero columns: divider returns all ones
            if (line == 0) begin
               lo = '1;
               hi = '1;
            end else begin
               lo = base / line;
               hi = top / line;
            end
            if (hi > {16'd0, final_row}) hi = {16'd0, final_row};
            widen_range(lo, hi);
         end
         ACT_FLUSH: begin
            flushed = 1'b1;
            s = track_first;
            e = track_last;
            track_first = final_row;
            track_last = '0;
            if (s > e || s > final_row || e > final_row) begin
               s = '0;
               e = final_row;
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_link_bytes(input logic [15:0] s, input logic [15:0] e,
                                   input logic [15:0] xe);
      logic [87:0] seq;
      link_beat_type beat;
      seq = {CMD_COLUMNS, 8'h00, 8'h00, xe[15:8], xe[7:0],
             CMD_PAGES, s[15:8], s[7:0], e[15:8], e[7:0], CMD_WRITE};
      for (int k = 0; k <= LAST_BYTE_IDX; k++) begin
         beat.is_parameter = PARAM_SLOTS[k];
         beat.link_byte = seq[87 - 8*k -: 8];
         beat.first_row = s[11:0];
         beat.last_row = e[11:0];
         beat.last = (k == LAST_BYTE_IDX);
         pending_bytes.push_back(beat);
      end
   endtask

   task automatic send_event(input panel_event_type ev);
      int unsigned gap;
      bit flushed;
      logic [15:0] s, e, xe;
      gap = pick_gap(send_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= ev.action;
      req_whole_frame <= ev.whole_frame;
      req_row_start <= ev.row_start;
      req_row_count <= ev.row_count;
      req_page_index <= ev.page_index;
      do @(posedge clock); while (!(req_valid && req_ready));
      track_event(ev, flushed, s, e, xe);
      if (flushed) begin
         if (ev.typed) begin
            s = ev.want_first;
            e = ev.want_last;
         end
         queue_link_bytes(s, e, xe);
      end
   endtask

   // hold the sender until every byte is out and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input logic idx, input logic [12:0] want);
      logic [31:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== {19'd0, want}) begin
         $display("%0t: register %0d readback expected %h got %h", $time, idx, want, rd);
         fault_count++;
      end
   endtask

   task automatic set_panel(input logic [12:0] columns, input logic [12:0] rows);
      logic [31:0] rd;
      csr_access(1'b1, REG_PANEL_COLUMNS, {19'd0, columns}, rd);
      csr_access(1'b1, REG_PANEL_ROWS, {19'd0, rows}, rd);
      cfg_columns = columns;
      cfg_rows = rows;
      check_register(REG_PANEL_COLUMNS, columns);
      check_register(REG_PANEL_ROWS, rows);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want !== got) begin
         $display("%0t: link byte %0d %s expected %h got %h", $time, beat_count, name,
                  want, got);
         fault_count++;
      end
   endtask

   task automatic check_beat();
      link_beat_type want;
      if (pending_bytes.size() == 0) begin
         $display("%0t: unexpected link byte %h expected none", $time, rsp_link_byte);
         fault_count++;
      end else begin
         want = pending_bytes.pop_front();
         compare_field("is_parameter", want.is_parameter, rsp_is_parameter);
         compare_field("link_byte", want.link_byte, rsp_link_byte);
         compare_field("window_first_row", want.first_row, rsp_window_first_row);
         compare_field("window_last_row", want.last_row, rsp_window_last_row);
         compare_field("last", want.last, rsp_last);
      end
      beat_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_beat();
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) hold_left = pick_gap(recv_calm);
         end
      end
   end

   initial begin
      logic [12:0] phase_columns[NUM_PHASES];
      logic [12:0] phase_rows[NUM_PHASES];

      phase_columns = '{13'd1, 13'd4096, 13'd0, 13'd0, 13'd480, 13'd8191, 13'd0, 13'd480};
      phase_rows    = '{13'd1, 13'd4096, 13'd0, 13'd320, 13'd0, 13'd8191, 13'd0, 13'd320};
      phase_columns[6] = 13'($urandom_range(1, 4096));
      phase_rows[6] = 13'($urandom_range(1, 4096));

      // reset defaults: 480 columns, 320 rows, last row 319, range 0..0
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 319));
      script.push_back(make_event(ACT_ROW_MARK, 0, 10, 5, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 10, 14));
      script.push_back(make_event(ACT_ROW_MARK, 1, 4095, 8191, 4095, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 319));
      script.push_back(make_event(ACT_ROW_MARK, 0, 0, 0, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 319));
      script.push_back(make_event(ACT_ROW_MARK, 0, 4095, 8191, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 319));
      script.push_back(make_event(ACT_ROW_MARK, 0, 319, 1, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 319, 319));
      script.push_back(make_event(ACT_PAGE_MARK, 0, 0, 0, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 4));
      script.push_back(make_event(ACT_PAGE_MARK, 0, 0, 0, 4095, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      script.push_back(make_event(ACT_PAGE_MARK, 0, 0, 0, 37, 0, 0, 0));
      script.push_back(make_event(ACT_ROW_MARK, 0, 100, 50, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      script.push_back(make_event(ACT_UNUSED, 1, 4095, 8191, 4095, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 1, 0, 319));
      script.push_back(make_event(ACT_ROW_MARK, 0, 0, 4096, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0));
      script.push_back(make_event(ACT_ROW_MARK, 0, 200, 0, 0, 0, 0, 0));
      script.push_back(make_event(ACT_FLUSH, 0, 0, 0, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_register(REG_PANEL_COLUMNS, PANEL_COLUMNS_RESET);
      check_register(REG_PANEL_ROWS, PANEL_ROWS_RESET);

      foreach (script[i]) send_event(script[i]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         set_panel(phase_columns[p], phase_rows[p]);
         send_calm = (p == 2 || p == 6);
         recv_calm = (p == 3 || p == 6);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 29) == 0) drain();
            send_event(random_event());
         end
      end

      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (fault_count == 0 && pending_bytes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending_bytes.size() != 0)
            $display("%0t: %0d link bytes expected but never sent", $time,
                     pending_bytes.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
